FILE: sv/msa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msa_pkg
// shared types, status codes and default sizes of the window slot allocator
// ----------------------------------------------------------------------------
package msa_pkg;

    // default sizes, handed to the top level parameters
    localparam int NUM_SLOTS_DEF  = 64;
    localparam int SLOT_BYTES_DEF = 65536;
    localparam int PAGE_BYTES_DEF = 4096;

    // fixed field widths of the item interface
    localparam int ADDR_W   = 64;
    localparam int REL_W    = 16;
    localparam int STATUS_W = 3;
    localparam int BYTES_W  = 23;
    localparam int GFIRST_W = 6;
    localparam int GCOUNT_W = 7;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_INVALID   = 3'd1;
    localparam t_status ST_BOUNDS    = 3'd2;
    localparam t_status ST_TOO_LARGE = 3'd3;
    localparam t_status ST_NO_RUN    = 3'd4;

    // operation codes
    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;         // capture the input item
        logic    stage_a;      // overflow and range checks
        logic    stage_b;      // page rounding
        logic    stage_c;      // slot count
        logic    scan_start;   // begin first-fit scan
        logic    claim_start;  // mark the found run busy
        logic    free_start;   // mark the release run free
        logic    init_start;   // clear every slot after reset
        logic    finish;       // load the result registers
        t_status code;         // status for finish
    } t_ctrl_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic op_unmap;
        logic unmap_bad;
        logic map_invalid;
        logic map_bounds;
        logic too_large;
        logic scan_found;
        logic scan_fail;
        logic sweep_idle;
    } t_dp_stat;

endpackage
`default_nettype wire

FILE: sv/mmio_window_slot_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmio_window_slot_allocator_top
// first-fit allocator of contiguous slot runs in an mmio mapping window
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   i_operation, i_phys_address,            start high, busy low
//            i_byte_size, i_release_first,
//            i_release_count
//  result    o_status, o_mapped_address,             o_valid, one cycle
//            o_phys_base, o_mapped_bytes,
//            o_granted_first, o_granted_count
//  config    i_cfg_wdata (window_base)               i_cfg_we
//
//  one item at a time; busy stays high until its result has been loaded
//  map: checks, then the one-slot-a-cycle first-fit bitmap scan, then the
//  one-slot-a-cycle claim sweep through the bitmap write port; a scan that
//  finds no run ends the item with ST_NO_RUN
//  unmap: sweep frees release_count slots; rejected items end at their check
//  after reset a clearing pass over all NUM_SLOTS slots holds busy high
//  the result shows for one cycle under o_valid; the receiver cannot stall
// ----------------------------------------------------------------------------
module mmio_window_slot_allocator_top #(
    parameter int NUM_SLOTS  = msa_pkg::NUM_SLOTS_DEF,
    parameter int SLOT_BYTES = msa_pkg::SLOT_BYTES_DEF,
    parameter int PAGE_BYTES = msa_pkg::PAGE_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request item
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_operation,
    input  wire logic [msa_pkg::ADDR_W-1:0]  i_phys_address,
    input  wire logic [msa_pkg::ADDR_W-1:0]  i_byte_size,
    input  wire logic [msa_pkg::REL_W-1:0]   i_release_first,
    input  wire logic [msa_pkg::REL_W-1:0]   i_release_count,
    // window_base register
    input  wire logic                        i_cfg_we,
    input  wire logic [msa_pkg::ADDR_W-1:0]  i_cfg_wdata,
    // result item
    output logic                             o_valid,
    output logic [msa_pkg::STATUS_W-1:0]     o_status,
    output logic [msa_pkg::ADDR_W-1:0]       o_mapped_address,
    output logic [msa_pkg::ADDR_W-1:0]       o_phys_base,
    output logic [msa_pkg::BYTES_W-1:0]      o_mapped_bytes,
    output logic [msa_pkg::GFIRST_W-1:0]     o_granted_first,
    output logic [msa_pkg::GCOUNT_W-1:0]     o_granted_count
);
    import msa_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // controller: request sequencing, clearing pass, busy
    msa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // datapath: size checks, slot bitmap, scan and sweep, result registers
    msa_dpath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .SLOT_BYTES (SLOT_BYTES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (i_operation),
        .i_phys_address   (i_phys_address),
        .i_byte_size      (i_byte_size),
        .i_release_first  (i_release_first),
        .i_release_count  (i_release_count),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_mapped_address (o_mapped_address),
        .o_phys_base      (o_phys_base),
        .o_mapped_bytes   (o_mapped_bytes),
        .o_granted_first  (o_granted_first),
        .o_granted_count  (o_granted_count)
    );

endmodule
`default_nettype wire

FILE: sv/msa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msa_ctrl
// sequencer for map and unmap requests, drives the datapath by commands
// ----------------------------------------------------------------------------
module msa_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire msa_pkg::t_dp_stat  i_stat,
    output msa_pkg::t_ctrl_cmd      o_cmd,
    output logic                    o_busy
);
    import msa_pkg::*;

    typedef enum logic [3:0] {
        S_INIT_GO,
        S_INIT_WAIT,
        S_IDLE,
        S_CHK_A,
        S_CHK_B,
        S_CHK_C,
        S_CHK_D,
        S_SCAN,
        S_CLAIM,
        S_FREE
    } t_state;

    t_state    r_state, n_state;
    logic      r_busy;
    t_ctrl_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_INIT_GO: begin
                cmd.init_start = 1'b1;
                n_state        = S_INIT_WAIT;
            end
            S_INIT_WAIT: begin
                if (i_stat.sweep_idle) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_CHK_A;
                end
            end
            S_CHK_A: begin
                cmd.stage_a = 1'b1;
                n_state     = S_CHK_B;
            end
            S_CHK_B: begin
                if (i_stat.op_unmap) begin
                    if (i_stat.unmap_bad) begin
                        cmd.finish = 1'b1;
                        cmd.code   = ST_INVALID;
                        n_state    = S_IDLE;
                    end else begin
                        cmd.free_start = 1'b1;
                        n_state        = S_FREE;
                    end
                end else if (i_stat.map_invalid) begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_INVALID;
                    n_state    = S_IDLE;
                end else begin
                    cmd.stage_b = 1'b1;
                    n_state     = S_CHK_C;
                end
            end
            S_CHK_C: begin
                if (i_stat.map_bounds) begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_BOUNDS;
                    n_state    = S_IDLE;
                end else begin
                    cmd.stage_c = 1'b1;
                    n_state     = S_CHK_D;
                end
            end
            S_CHK_D: begin
                if (i_stat.too_large) begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_TOO_LARGE;
                    n_state    = S_IDLE;
                end else begin
                    cmd.scan_start = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_found) begin
                    cmd.claim_start = 1'b1;
                    n_state         = S_CLAIM;
                end else if (i_stat.scan_fail) begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_NO_RUN;
                    n_state    = S_IDLE;
                end
            end
            S_CLAIM, S_FREE: begin
                if (i_stat.sweep_idle) begin
                    cmd.finish = 1'b1;
                    cmd.code   = ST_OK;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_GO;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

endmodule
`default_nettype wire

FILE: sv/msa_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msa_dpath
// request registers, size arithmetic, slot bitmap, scan and sweep units
// ----------------------------------------------------------------------------
module msa_dpath #(
    parameter int NUM_SLOTS  = msa_pkg::NUM_SLOTS_DEF,
    parameter int SLOT_BYTES = msa_pkg::SLOT_BYTES_DEF,
    parameter int PAGE_BYTES = msa_pkg::PAGE_BYTES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire msa_pkg::t_ctrl_cmd          i_cmd,
    output msa_pkg::t_dp_stat                o_stat,
    input  wire logic                        i_cfg_we,
    input  wire logic [msa_pkg::ADDR_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_operation,
    input  wire logic [msa_pkg::ADDR_W-1:0]  i_phys_address,
    input  wire logic [msa_pkg::ADDR_W-1:0]  i_byte_size,
    input  wire logic [msa_pkg::REL_W-1:0]   i_release_first,
    input  wire logic [msa_pkg::REL_W-1:0]   i_release_count,
    output logic                             o_valid,
    output logic [msa_pkg::STATUS_W-1:0]     o_status,
    output logic [msa_pkg::ADDR_W-1:0]       o_mapped_address,
    output logic [msa_pkg::ADDR_W-1:0]       o_phys_base,
    output logic [msa_pkg::BYTES_W-1:0]      o_mapped_bytes,
    output logic [msa_pkg::GFIRST_W-1:0]     o_granted_first,
    output logic [msa_pkg::GCOUNT_W-1:0]     o_granted_count
);
    import msa_pkg::*;

    localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W    = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_LOG = $clog2(SLOT_BYTES);
    localparam logic [ADDR_W-1:0] PMASK = ADDR_W'(PAGE_BYTES - 1);
    localparam logic [ADDR_W-1:0] SMASK = ADDR_W'(SLOT_BYTES - 1);
    localparam int RW = REL_W + 1;

    // request and arithmetic registers
    logic              r_op;
    logic [ADDR_W-1:0] r_addr, r_size, r_req, r_mapped, r_win_off;
    logic [REL_W-1:0]  r_rel_first, r_rel_count;
    logic              r_invalid, r_bounds, r_too_large, r_unmap_bad;
    logic [CNT_W-1:0]  r_need;
    logic [ADDR_W-1:0] r_window_base;

    // bitmap, one read and one write port
    logic              r_slot_busy [NUM_SLOTS];

    // sweep unit
    logic [CNT_W-1:0]  r_sw_ptr, r_sw_left;
    logic              r_sw_val;

    // scan unit
    logic              r_scan_act, r_rd_vld, r_rd_bit, r_found, r_fail;
    logic [CNT_W-1:0]  r_rd_ptr, r_run;
    logic [IDX_W-1:0]  r_rd_idx, r_found_first;

    // result registers
    logic              r_valid;
    t_status           r_status;
    logic [ADDR_W-1:0] r_o_addr, r_o_pbase;
    logic [BYTES_W-1:0] r_o_bytes;
    logic [GFIRST_W-1:0] r_o_first;
    logic [GCOUNT_W-1:0] r_o_count;

    logic [ADDR_W:0]   sum_a, sum_b;
    logic [ADDR_W-1:0] offset, slots;
    logic [RW-1:0]     rel_end;
    logic              rd_free_hit;
    logic [CNT_W:0]    run_inc;

    assign offset  = r_addr & PMASK;
    assign sum_a   = {1'b0, r_addr} + {1'b0, r_size};
    assign sum_b   = {1'b0, r_req} + {1'b0, PMASK};
    assign slots   = (r_mapped >> SLOT_LOG) + ADDR_W'(|(r_mapped & SMASK));
    assign rel_end = RW'(r_rel_first) + RW'(r_rel_count);
    assign run_inc = (CNT_W+1)'(r_run) + (CNT_W+1)'(1);
    assign rd_free_hit = !r_rd_bit && (run_inc == (CNT_W+1)'(r_need));

    // bitmap memory
    always_ff @(posedge i_clk) begin
        if (r_sw_left != '0) begin
            r_slot_busy[r_sw_ptr[IDX_W-1:0]] <= r_sw_val;
        end
        r_rd_bit <= r_slot_busy[r_rd_ptr[IDX_W-1:0]];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_base <= '0;
            r_sw_left     <= '0;
            r_scan_act    <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_found       <= 1'b0;
            r_fail        <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window_base <= i_cfg_wdata;
            end
            r_valid <= i_cmd.finish;

            if (i_cmd.init_start) begin
                r_sw_left <= CNT_W'(NUM_SLOTS);
            end else if (i_cmd.claim_start) begin
                r_sw_left <= r_need;
            end else if (i_cmd.free_start) begin
                r_sw_left <= r_rel_count[CNT_W-1:0];
            end else if (r_sw_left != '0) begin
                r_sw_left <= r_sw_left - CNT_W'(1);
            end

            if (i_cmd.scan_start) begin
                r_scan_act <= 1'b1;
                r_rd_vld   <= 1'b0;
                r_found    <= 1'b0;
                r_fail     <= 1'b0;
            end else if (r_scan_act) begin
                r_rd_vld <= (r_rd_ptr < CNT_W'(NUM_SLOTS));
                if (r_rd_vld) begin
                    if (rd_free_hit) begin
                        r_found    <= 1'b1;
                        r_scan_act <= 1'b0;
                    end else if (r_rd_idx == IDX_W'(NUM_SLOTS - 1)) begin
                        r_fail     <= 1'b1;
                        r_scan_act <= 1'b0;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_operation;
            r_addr      <= i_phys_address;
            r_size      <= i_byte_size;
            r_rel_first <= i_release_first;
            r_rel_count <= i_release_count;
        end
        if (i_cmd.stage_a) begin
            r_invalid   <= (r_size == '0) || sum_a[ADDR_W];
            r_req       <= offset + r_size;
            r_unmap_bad <= (r_rel_count == '0)
                        || (RW'(r_rel_first) >= RW'(NUM_SLOTS))
                        || (rel_end > RW'(NUM_SLOTS));
        end
        if (i_cmd.stage_b) begin
            r_bounds <= sum_b[ADDR_W];
            r_mapped <= sum_b[ADDR_W-1:0] & ~PMASK;
        end
        if (i_cmd.stage_c) begin
            r_too_large <= (slots > ADDR_W'(NUM_SLOTS));
            r_need      <= slots[CNT_W-1:0];
        end

        // sweep walks the run one slot a cycle
        if (i_cmd.init_start) begin
            r_sw_ptr <= '0;
            r_sw_val <= 1'b0;
        end else if (i_cmd.claim_start) begin
            r_sw_ptr <= CNT_W'(r_found_first);
            r_sw_val <= 1'b1;
        end else if (i_cmd.free_start) begin
            r_sw_ptr <= r_rel_first[CNT_W-1:0];
            r_sw_val <= 1'b0;
        end else if (r_sw_left != '0) begin
            r_sw_ptr <= r_sw_ptr + CNT_W'(1);
        end

        // scan: read one slot a cycle, count the free run behind it
        if (i_cmd.scan_start) begin
            r_rd_ptr <= '0;
            r_run    <= '0;
        end else if (r_scan_act) begin
            if (r_rd_ptr < CNT_W'(NUM_SLOTS)) begin
                r_rd_ptr <= r_rd_ptr + CNT_W'(1);
            end
            r_rd_idx <= r_rd_ptr[IDX_W-1:0];
            if (r_rd_vld) begin
                r_run <= r_rd_bit ? '0 : run_inc[CNT_W-1:0];
                if (rd_free_hit) begin
                    r_found_first <= IDX_W'((CNT_W+1)'(r_rd_idx) + (CNT_W+1)'(1)
                                     - (CNT_W+1)'(r_need));
                end
            end
        end

        if (i_cmd.claim_start) begin
            r_win_off <= (ADDR_W'(r_found_first) << SLOT_LOG) + offset;
        end

        if (i_cmd.finish) begin
            r_status <= i_cmd.code;
            if (i_cmd.code == ST_OK && r_op == OP_MAP) begin
                r_o_addr  <= r_window_base + r_win_off;
                r_o_pbase <= r_addr & ~PMASK;
                r_o_bytes <= r_mapped[BYTES_W-1:0];
                r_o_first <= GFIRST_W'(r_found_first);
                r_o_count <= GCOUNT_W'(r_need);
            end else begin
                r_o_addr  <= '0;
                r_o_pbase <= '0;
                r_o_bytes <= '0;
                r_o_first <= '0;
                r_o_count <= '0;
            end
        end
    end

    always_comb begin
        o_stat             = '0;
        o_stat.op_unmap    = (r_op == OP_UNMAP);
        o_stat.unmap_bad   = r_unmap_bad;
        o_stat.map_invalid = r_invalid;
        o_stat.map_bounds  = r_bounds;
        o_stat.too_large   = r_too_large;
        o_stat.scan_found  = r_found;
        o_stat.scan_fail   = r_fail;
        o_stat.sweep_idle  = (r_sw_left == '0);
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_mapped_address = r_o_addr;
    assign o_phys_base      = r_o_pbase;
    assign o_mapped_bytes   = r_o_bytes;
    assign o_granted_first  = r_o_first;
    assign o_granted_count  = r_o_count;

endmodule
`default_nettype wire
